@@ hdl/hid_key_report_builder_assert.svh @@
// assertion macros shared by the report builder rtl
// expects clk and rst in the scope of each use
`ifndef HID_KEY_REPORT_BUILDER_ASSERT_SVH
`define HID_KEY_REPORT_BUILDER_ASSERT_SVH

// condition a implies condition c in the same cycle
`define HKRB_ASSERT_SAME(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("hkrb same-cycle check failed");

// condition a implies condition c in the next cycle
`define HKRB_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("hkrb next-cycle check failed");

`endif

@@ hdl/hkrb_pkg.sv @@
// shared types and constants for the hid key report builder
// no dependencies
package hkrb_pkg;

  localparam int KEY_SLOTS_DEFAULT      = 6;
  localparam int MODIFIER_BASE_DEFAULT  = 224;
  localparam int MODIFIER_COUNT_DEFAULT = 8;
  localparam int REPORTED_SLOTS         = 6;
  localparam int CODE_W                 = 8;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BUSY      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic         load;        // latch input word, rewind scan
    logic         advance;     // step to next slot
    logic         mod_update;  // apply modifier press or release
    logic         slot_write;  // write current slot
    logic         set_status;  // record status code
    status_code_t status;
    logic         emit;        // load output register
  } hkrb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pressed;
    logic is_mod;
    logic hit;
    logic last;
    logic out_busy;
  } hkrb_stat_t;

endpackage

@@ hdl/hkrb_datapath.sv @@
// datapath: modifier mask, key slots, scan index and output register
// depends on hkrb_pkg
module hkrb_datapath #(
  parameter int KEY_SLOTS      = hkrb_pkg::KEY_SLOTS_DEFAULT,
  parameter int MODIFIER_BASE  = hkrb_pkg::MODIFIER_BASE_DEFAULT,
  parameter int MODIFIER_COUNT = hkrb_pkg::MODIFIER_COUNT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  hkrb_pkg::hkrb_cmd_t cmd,
  output hkrb_pkg::hkrb_stat_t stat,
  input  logic                in_pressed,
  input  logic [7:0]          in_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [55:0]         out_report
);
  import hkrb_pkg::*;

  localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [8:0] MOD_BASE  = 9'(MODIFIER_BASE);
  localparam logic [8:0] MOD_COUNT = 9'(MODIFIER_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

  logic              pressed;
  logic [7:0]        code;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        status;
  logic [7:0]        mods;
  logic [7:0]        slots [KEY_SLOTS];
  logic [8:0]        mod_off;
  logic [7:0]        mod_mask;
  logic [7:0]        target;
  logic [55:0]       report;

  assign mod_off  = {1'b0, code} - MOD_BASE;
  assign mod_mask = 8'b1 << mod_off[2:0];
  assign target   = pressed ? 8'd0 : code;

  assign stat.pressed  = pressed;
  assign stat.is_mod   = ({1'b0, code} >= MOD_BASE) && (mod_off < MOD_COUNT);
  assign stat.hit      = (slots[idx] == target);
  assign stat.last     = (idx == LAST_IDX);
  assign stat.out_busy = out_valid && !out_ready;

  // report view: modifier byte, then reported slots, absent slots read zero
  assign report[7:0] = mods;
  for (genvar j = 0; j < REPORTED_SLOTS; j++) begin : g_rep
    if (j < KEY_SLOTS) begin : g_have
      assign report[8*j+15 -: 8] = slots[j];
    end else begin : g_none
      assign report[8*j+15 -: 8] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pressed <= in_pressed;
      code    <= in_code;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
    if (cmd.emit) begin
      out_status <= status;
      out_report <= report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      mods      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.advance) begin
        idx <= idx + 1'b1;
      end
      if (cmd.mod_update) begin
        mods <= pressed ? (mods | mod_mask) : (mods & ~mod_mask);
      end
      if (cmd.slot_write) begin
        slots[idx] <= pressed ? code : 8'd0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/hkrb_controller.sv @@
// controller: sequences accept, slot scan and result hand-off
// depends on hkrb_pkg and hid_key_report_builder_assert.svh
`include "hid_key_report_builder_assert.svh"

module hkrb_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hkrb_pkg::hkrb_stat_t stat,
  output hkrb_pkg::hkrb_cmd_t  cmd
);
  import hkrb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = STATUS_OK;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (stat.is_mod) begin
          cmd.mod_update = 1'b1;
          cmd.set_status = 1'b1;
          state_next     = ST_EMIT;
        end else if (stat.hit) begin
          cmd.slot_write = 1'b1;
          cmd.set_status = 1'b1;
          state_next     = ST_EMIT;
        end else if (stat.last) begin
          cmd.set_status = 1'b1;
          cmd.status     = stat.pressed ? STATUS_BUSY : STATUS_NOT_FOUND;
          state_next     = ST_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `HKRB_ASSERT_SAME(a_emit_free, cmd.emit, !stat.out_busy)
  `HKRB_ASSERT_SAME(a_write_hit, cmd.slot_write, stat.hit && !stat.is_mod)
  `HKRB_ASSERT_SAME(a_adv_not_last, cmd.advance, !stat.last && !stat.hit)
  `HKRB_ASSERT_NEXT(a_load_scan, cmd.load, state == ST_SCAN && !in_ready)

endmodule

@@ hdl/hid_key_report_builder.sv @@
// hid key report builder: keeps a boot-keyboard report (modifier byte and
// key slots) from a stream of press and release events, one result word per
// event word. a modifier code sets its bit on press and clears it on release;
// any other code fills the first empty slot on press or clears the first
// matching slot on release. the slot registers are scanned one slot per
// cycle, and one event is scanned at a time. the result sits in an output
// register, so a stalled master side holds it while the next event is taken
// and scanned.
// depends on hkrb_pkg, hkrb_controller and hkrb_datapath
module hid_key_report_builder #(
  parameter int KEY_SLOTS      = hkrb_pkg::KEY_SLOTS_DEFAULT,
  parameter int MODIFIER_BASE  = hkrb_pkg::MODIFIER_BASE_DEFAULT,
  parameter int MODIFIER_COUNT = hkrb_pkg::MODIFIER_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // event side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
  input  logic        s_axis_tuser,   // [0] pressed
  // report side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] modifier_bits, [15:8] slot_zero, [23:16] slot_one,
  // [31:24] slot_two, [39:32] slot_three, [47:40] slot_four, [55:48] slot_five
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import hkrb_pkg::*;

  hkrb_cmd_t  cmd;   // sequencing commands
  hkrb_stat_t stat;  // scan and output status

  hkrb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot and modifier storage plus output register
  hkrb_datapath #(
    .KEY_SLOTS      (KEY_SLOTS),
    .MODIFIER_BASE  (MODIFIER_BASE),
    .MODIFIER_COUNT (MODIFIER_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_pressed (s_axis_tuser),
    .in_code    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_report (m_axis_tdata)
  );

endmodule

@@ sim/hkrb_report_checker.sv @@
// report checker for the hid key report builder: watches both stream sides,
// keeps its own copy of the modifier byte and key slots, compares each report
// depends on hkrb_pkg
module hkrb_report_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
  input  logic        s_axis_tuser,   // [0] pressed
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] modifier_bits, [15:8] slot_zero .. [55:48] slot_five
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  output int          errors,
  output int          pending,
  output int          checked,
  output int          busy_seen,
  output int          missing_seen
);
  import hkrb_pkg::*;

  typedef struct packed {
    status_code_t                         status;
    logic [7:0]                           mods;
    logic [REPORTED_SLOTS-1:0][CODE_W-1:0] slots;
  } key_report_t;

  logic [7:0]        held_mods;
  logic [CODE_W-1:0] held_slots [KEY_SLOTS_DEFAULT];
  key_report_t       report_q [$];
  int                err_cnt;
  int                chk_cnt;
  int                busy_cnt;
  int                miss_cnt;

  // updates the held report for one key event and returns what the block must show
  function automatic key_report_t apply_key_event(input logic press, input logic [7:0] code);
    key_report_t r;
    logic [7:0]  mask;
    int          off;
    mask = 8'h00;
    off  = int'(code) - MODIFIER_BASE_DEFAULT;
    if (off >= 0 && off < MODIFIER_COUNT_DEFAULT && off < 8) begin
      mask = 8'h01 << off;
    end
    r.status = STATUS_OK;
    if (mask != 8'h00) begin
      held_mods = press ? (held_mods | mask) : (held_mods & ~mask);
    end else if (press) begin
      r.status = STATUS_BUSY;
      for (int i = 0; i < KEY_SLOTS_DEFAULT; i++) begin
        if (held_slots[i] == '0) begin
          held_slots[i] = code;
          r.status      = STATUS_OK;
          break;
        end
      end
    end else begin
      r.status = STATUS_NOT_FOUND;
      for (int i = 0; i < KEY_SLOTS_DEFAULT; i++) begin
        if (held_slots[i] == code) begin
          held_slots[i] = '0;
          r.status      = STATUS_OK;
          break;
        end
      end
    end
    r.mods = held_mods;
    for (int j = 0; j < REPORTED_SLOTS; j++) begin
      r.slots[j] = (j < KEY_SLOTS_DEFAULT) ? held_slots[j] : '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    key_report_t exp_r;
    if (rst) begin
      held_mods = '0;
      for (int i = 0; i < KEY_SLOTS_DEFAULT; i++) held_slots[i] = '0;
      report_q.delete();
    end else begin
      // reports first: the block never answers an event in the cycle it takes it
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          $display("%0t: report with no event waiting, status %0d data %h", $time,
                   m_axis_tuser, m_axis_tdata);
          err_cnt++;
        end else begin
          exp_r = report_q.pop_front();
          chk_cnt++;
          if (exp_r.status == STATUS_BUSY) busy_cnt++;
          if (exp_r.status == STATUS_NOT_FOUND) miss_cnt++;
          if (m_axis_tuser != exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[7:0] != exp_r.mods) begin
            $display("%0t: modifier_bits expected %h actual %h", $time, exp_r.mods,
                     m_axis_tdata[7:0]);
            err_cnt++;
          end
          for (int j = 0; j < REPORTED_SLOTS; j++) begin
            if (m_axis_tdata[8*(j+1) +: 8] != exp_r.slots[j]) begin
              $display("%0t: slot %0d expected %h actual %h", $time, j, exp_r.slots[j],
                       m_axis_tdata[8*(j+1) +: 8]);
              err_cnt++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(apply_key_event(s_axis_tuser, s_axis_tdata));
      end
    end
    errors       <= err_cnt;
    pending      <= report_q.size();
    checked      <= chk_cnt;
    busy_seen    <= busy_cnt;
    missing_seen <= miss_cnt;
  end

endmodule

@@ sim/tb_hid_key_report_builder.sv @@
// testbench top for the hid key report builder: drives key events, stalls
// the report side, runs a watchdog and gives the verdict
// depends on hkrb_pkg, hid_key_report_builder and hkrb_report_checker
module tb_hid_key_report_builder;
  import hkrb_pkg::*;

  localparam int EVENTS_RANDOM = 600;
  localparam int STALL_LIMIT   = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES  = 16;    // extra wait after the last report, for anything stray

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] key_code
  logic        s_axis_tuser  = 1'b0;   // [0] pressed
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] modifier_bits, [15:8] slot_zero .. [55:48] slot_five
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;           // [1:0] status

  int          errors;
  int          pending;
  int          checked;
  int          busy_seen;
  int          missing_seen;
  logic        calm = 1'b0;            // no idling on either side while high
  int          sent = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  hid_key_report_builder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  hkrb_report_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked),
    .busy_seen     (busy_seen),
    .missing_seen  (missing_seen)
  );

  // report side stalls at random, with odds of 16 in 100, never while calm
  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // watchdog on cycles where no word moves
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: watchdog, no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // offers one event word, with a random gap in front unless calm; entered
  // and left at a rising edge. ready is sampled on the falling edge, where it
  // is stable, to know whether the next rising edge takes the word
  task automatic send_event(input logic press, input logic [7:0] code);
    logic took;
    while (!calm && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= press;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  initial begin
    int         pick;
    int         press_bias;
    int         directed;
    logic       press;
    logic [7:0] code;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    send_event(1'b0, 8'h00);  // release of code zero on an empty report
    send_event(1'b1, 8'hE0);  // lowest modifier
    send_event(1'b1, 8'hE7);  // highest modifier
    send_event(1'b1, 8'hE0);  // setting a bit already set
    send_event(1'b0, 8'hE3);  // clearing a bit already clear
    send_event(1'b0, 8'hE0);
    send_event(1'b1, 8'hDF);  // just below the modifier range, slot 0
    send_event(1'b1, 8'hE8);  // just above it, slot 1
    send_event(1'b1, 8'hFF);
    send_event(1'b1, 8'h01);
    send_event(1'b1, 8'h04);
    send_event(1'b1, 8'h04);  // duplicate press takes the last slot
    send_event(1'b1, 8'h05);  // every slot full
    send_event(1'b1, 8'h00);  // code zero with every slot full
    send_event(1'b0, 8'h00);  // code zero release with no empty slot
    send_event(1'b0, 8'h04);  // first of two matches is cleared
    send_event(1'b0, 8'h77);  // key never pressed
    send_event(1'b1, 8'h00);  // code zero into the empty slot, report unchanged
    send_event(1'b1, 8'hAA);
    send_event(1'b0, 8'hDF);
    send_event(1'b1, 8'h55);  // refills slot 0
    send_event(1'b0, 8'hE7);
    send_event(1'b1, 8'hE7);  // modifier still ok with the slots full
    send_event(1'b0, 8'hFF);
    directed = sent;

    // random part: mostly a small pool of keys so releases find their slot,
    // alternating press-heavy and release-heavy phases to reach full and
    // empty reports, plus modifiers, code zero and raw noise
    for (int n = 0; n < EVENTS_RANDOM; n++) begin
      calm       <= (n >= 250 && n < 400);
      pick       = $urandom_range(0, 99);
      press_bias = ((n / 40) % 2 == 0) ? 75 : 25;
      if (pick < 70) begin
        code  = 8'($urandom_range(4, 12));
        press = ($urandom_range(0, 99) < press_bias);
      end else if (pick < 85) begin
        code  = 8'(MODIFIER_BASE_DEFAULT + $urandom_range(0, MODIFIER_COUNT_DEFAULT - 1));
        press = 1'($urandom_range(0, 1));
      end else if (pick < 88) begin
        code  = 8'h00;
        press = 1'($urandom_range(0, 1));
      end else begin
        code  = 8'($urandom_range(0, 255));
        press = 1'($urandom_range(0, 1));
      end
      send_event(press, code);
    end
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;

    // let the checker count the last event, then drain, then wait DRAIN_CYCLES
    // more for anything stray
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d key events (%0d directed), %0d reports checked", sent, directed,
             checked);
    $display("summary: %0d presses with every slot full, %0d releases of absent keys",
             busy_seen, missing_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/hkrb_pkg.sv
hdl/hkrb_datapath.sv
hdl/hkrb_controller.sv
hdl/hid_key_report_builder.sv
sim/hkrb_report_checker.sv
sim/tb_hid_key_report_builder.sv
